/* rtl/sitoa_pkg.sv */
package sitoa_pkg;

    // width of the two's complement input value
    localparam int VALUE_WIDTH = 32;

    // decimal digits needed for 2^(VALUE_WIDTH-1), log10(2) ~ 1233/4096
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;

    localparam int STEP_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int PTR_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [5:0] CHR_ZERO  = 6'd48;
    localparam logic [5:0] CHR_MINUS = 6'd45;
    localparam logic [3:0] BCD_FIVE  = 4'd5;
    localparam logic [3:0] BCD_THREE = 4'd3;

    typedef struct packed {
        logic load;      // capture magnitude and sign, clear digits
        logic shift;     // one shift-add-3 conversion step
        logic find;      // point at the most significant nonzero digit
        logic dec;       // move to the next lower digit
        logic minus;     // present the minus sign instead of a digit
    } sitoa_cmd_t;

    typedef struct packed {
        logic last_step; // final conversion step is underway
        logic neg;       // current value is negative
        logic ptr_zero;  // pointer is at the units digit
    } sitoa_status_t;

endpackage

/* rtl/sitoa_dp.sv */
module sitoa_dp
    import sitoa_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sitoa_cmd_t                    cmd,
    output sitoa_status_t                 status,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic [5:0]                    char_code
);

    logic [VALUE_WIDTH-1:0]           bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][3:0]       bcd_reg, bcd_next, bcd_adj;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [PTR_W-1:0]                 ptr_reg, ptr_next, msd;
    logic                             neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0]           mag;
    logic [NUM_DIGITS*4-1:0]          bcd_flat;

    assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    // add-3 correction on every digit of five or more
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] >= BCD_FIVE)
            begin
                bcd_adj[i] = bcd_reg[i] + BCD_THREE;
            end
        end
    end

    assign bcd_flat = bcd_adj;

    // highest nonzero digit, units digit when all are zero
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                msd = PTR_W'(i);
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        ptr_next  = ptr_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            step_next = '0;
            neg_next  = value[VALUE_WIDTH-1];
        end
        else if (cmd.shift)
        begin
            bcd_next  = {bcd_flat[NUM_DIGITS*4-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next  = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            step_next = step_reg + 1'b1;
        end
        if (cmd.find)
        begin
            ptr_next = msd;
        end
        else if (cmd.dec)
        begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ptr_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            ptr_reg  <= ptr_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.last_step = (step_reg == STEP_W'(VALUE_WIDTH - 1));
    assign status.neg       = neg_reg;
    assign status.ptr_zero  = (ptr_reg == '0);

    assign char_code = cmd.minus ? CHR_MINUS : (CHR_ZERO + {2'b00, bcd_reg[ptr_reg]});

endmodule

/* rtl/sitoa_ctrl.sv */
module sitoa_ctrl
    import sitoa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          last,
    output sitoa_cmd_t    cmd,
    input  sitoa_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                out_valid = 1'b1;
                cmd.minus = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                out_valid = 1'b1;
                last      = status.ptr_zero;
                if (out_ready)
                begin
                    if (status.ptr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.dec = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// signed integer to decimal ascii: each input word carries one two's complement
// integer and the block returns its decimal text, one ascii character per
// output word, most significant digit first, with last high on the final
// character. a negative value starts with '-' and the most negative value
// prints its full magnitude; zero prints a single '0'. one value is handled
// at a time: after the input word is taken the magnitude is converted to bcd
// by a shift-add-3 loop, one bit per cycle, then a find state locates the
// leading digit, then the characters go out one per cycle while out_ready is
// high.
module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    // output channel, one character per word
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [5:0]                    char_code,
    output logic                          last
);

    // commands from the sequencer, status back from the datapath
    sitoa_cmd_t    cmd;
    sitoa_status_t status;

    // sequencer: accept, convert, find leading digit, emit sign and digits
    sitoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: magnitude, bcd digits, digit pointer and character select
    sitoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .char_code (char_code)
    );

endmodule
